// ===== rtl/jri_pkg.sv =====
// jri_pkg: shared constants, register codes and types of the joystick rate integrator
// no dependencies; imported by jri_if, jri_regs and the top level
`timescale 1ns / 1ps

package jri_pkg;

  // default parameter values
  localparam int DefChannels   = 4;
  localparam int DefSampleBits = 10;

  // fixed field widths
  localparam int LaneW     = 16;  // one channel's lane in a 64-bit table
  localparam int TableW    = 64;
  localparam int DeadbandW = 9;
  localparam int InvertW   = 4;
  localparam int ChanW     = 2;
  localparam int PosW      = 32;  // signed Q16.16 position
  localparam int SumW      = PosW + 2;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 64;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegDeadband  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegStepTable = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLowLimit  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegHighLimit = 3'd3;
  localparam logic [CfgIdxW-1:0] RegInvert    = 3'd4;

  // request opcodes
  localparam logic OpSample = 1'b0;
  localparam logic OpZero   = 1'b1;

  // register values after reset
  localparam logic [DeadbandW-1:0] RstDeadband  = 9'd0;
  localparam logic [TableW-1:0]    RstStepTable = 64'd5534107667397623808;
  localparam logic [TableW-1:0]    RstLowLimit  = 64'd281346127757313;
  localparam logic [TableW-1:0]    RstHighLimit = 64'd28147626532537020;
  localparam logic [InvertW-1:0]   RstInvert    = 4'd5;

  // configuration seen by the datapath
  typedef struct packed {
    logic [DeadbandW-1:0] deadband;
    logic [TableW-1:0]    step_table;
    logic [TableW-1:0]    low_limit_table;
    logic [TableW-1:0]    high_limit_table;
    logic [InvertW-1:0]   invert_mask;
  } cfg_t;

endpackage

// ===== rtl/jri_if.sv =====
// jri_if: valid/ready channel interfaces for samples, results and configuration writes
// depends on jri_pkg
`timescale 1ns / 1ps

interface jri_in_if #(
  parameter int SAMPLE_BITS = jri_pkg::DefSampleBits
);
  import jri_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    op;
  logic [ChanW-1:0]        channel_select;
  logic [SAMPLE_BITS-1:0]  sample;

  modport source (output valid, op, channel_select, sample, input ready);
  modport sink (input valid, op, channel_select, sample, output ready);
endinterface

interface jri_out_if;
  import jri_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [ChanW-1:0]       out_channel;
  logic signed [PosW-1:0] position;

  modport source (output valid, out_channel, position, input ready);
  modport sink (input valid, out_channel, position, output ready);
endinterface

interface jri_cfg_if;
  import jri_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/jri_regs.sv =====
// jri_regs: configuration register file written through the configuration channel
// depends on jri_pkg and jri_if
`timescale 1ns / 1ps

module jri_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  jri_cfg_if.sink        cfg_chan,
  output jri_pkg::cfg_t  cfg_o
);
  import jri_pkg::*;

  cfg_t cfg_q;

  // writes are always taken
  assign cfg_chan.ready = 1'b1;
  assign cfg_o          = cfg_q;

  // register write decode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deadband         <= RstDeadband;
      cfg_q.step_table       <= RstStepTable;
      cfg_q.low_limit_table  <= RstLowLimit;
      cfg_q.high_limit_table <= RstHighLimit;
      cfg_q.invert_mask      <= RstInvert;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        RegDeadband:  cfg_q.deadband         <= cfg_chan.data[DeadbandW-1:0];
        RegStepTable: cfg_q.step_table       <= cfg_chan.data[TableW-1:0];
        RegLowLimit:  cfg_q.low_limit_table  <= cfg_chan.data[TableW-1:0];
        RegHighLimit: cfg_q.high_limit_table <= cfg_chan.data[TableW-1:0];
        RegInvert:    cfg_q.invert_mask      <= cfg_chan.data[InvertW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/jri_div.sv =====
// jri_div: restoring serial divider, one quotient bit per cycle
// depends on jri_pkg only for the file order; no imports needed
`timescale 1ns / 1ps

module jri_div #(
  parameter int NUM_W = 26,
  parameter int DEN_W = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quotient_o
);

  localparam int CntW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             fits;

  // one restoring step: bring down the next dividend bit
  always_comb begin
    shifted = {rem_q, quo_q[NUM_W-1]};
    diff    = shifted - {1'b0, den_q};
    fits    = shifted >= {1'b0, den_q};
    rem_d   = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    quo_d   = {quo_q[NUM_W-2:0], fits};
  end

  // sequencing of the iterations
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NUM_W);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/joystick_rate_integrator.sv =====
// joystick_rate_integrator: top level, sequencer, channel positions and result register
// depends on jri_pkg, jri_if, jri_regs and jri_div
`timescale 1ns / 1ps

// Usage:
// in_chan carries requests: op, channel_select and a raw stick reading.
// A sample request moves the selected channel's Q16.16 position by the
// deadband-shaped, step-scaled increment, clips it to the channel limits and
// returns one result (out_channel, position) on out_chan. A zero request
// clears every position at once and returns nothing. A sample for a channel
// number at or above CHANNELS returns nothing and changes no position.
// cfg_chan writes the five configuration registers and is always ready; the
// user must see that it is written only while no request is in flight; the
// block does not enforce this. A sample request passes through the prepare,
// divide, sum and clip steps; the serial divider produces one quotient bit
// per cycle over SAMPLE_BITS + 16 bits. in_chan is not ready while a sample
// is in flight, so a new sample is taken only once the last has left the
// clip step; a zero request leaves in_chan ready.
// A finished result waits in the output register; if out_chan stalls, the
// next result holds in the clip step until the register frees.
// Reset clears all positions, loads the register defaults and empties the
// output register.

module joystick_rate_integrator #(
  parameter int CHANNELS    = jri_pkg::DefChannels,
  parameter int SAMPLE_BITS = jri_pkg::DefSampleBits
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  jri_in_if.sink   in_chan,
  jri_out_if.source out_chan,
  jri_cfg_if.sink  cfg_chan
);
  import jri_pkg::*;

  localparam int FullScale = 2 ** SAMPLE_BITS - 1;
  localparam int Center    = FullScale / 2;
  localparam int CmpW      = SAMPLE_BITS + 2;
  localparam int ProdW     = SAMPLE_BITS + LaneW;
  localparam int LaneSelW  = $clog2(TableW);

  // sequencer states
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPrep = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StSum  = 3'd3;
  localparam logic [2:0] StClip = 3'd4;

  cfg_t cfg;

  logic [2:0]                  state_q, state_d;
  logic [ChanW-1:0]            ch_q;
  logic [SAMPLE_BITS-1:0]      num_q, num_d;
  logic [SAMPLE_BITS-1:0]      den_q, den_d;
  logic                        neg_q, neg_d;
  logic signed [SumW-1:0]      sum_q;
  logic signed [PosW-1:0]      pos_q [CHANNELS];
  logic                        out_valid_q;
  logic [ChanW-1:0]            out_channel_q;
  logic signed [PosW-1:0]      position_q;

  logic                        in_acc;
  logic                        ch_ok;
  logic [CmpW-1:0]             raw_w, db_w, ctr_w;
  logic [CmpW-1:0]             num_above, den_above, num_below;
  logic                        above, below;
  logic [LaneSelW-1:0]         lane_base;
  logic [LaneW-1:0]            step_lane, lo_lane, hi_lane;
  logic signed [SumW-1:0]      lo_q16, hi_q16;
  logic signed [SumW-1:0]      inc, pos_ext;
  logic signed [PosW-1:0]      pos_sel;
  logic signed [SumW-1:0]      clip_val;
  logic [ProdW-1:0]            product;
  logic                        div_start, div_done;
  logic [ProdW-1:0]            quotient;
  logic                        out_load;
  logic                        all_zero;

  jri_regs u_regs (
    .clk_i,
    .rst_ni,
    .cfg_chan,
    .cfg_o (cfg)
  );

  // request handshake
  assign in_chan.ready = (state_q == StIdle);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign ch_ok         = int'(in_chan.channel_select) < CHANNELS;

  // dead zone classification of the incoming reading
  always_comb begin
    raw_w     = CmpW'(in_chan.sample);
    db_w      = CmpW'(cfg.deadband);
    ctr_w     = CmpW'(Center);
    above     = raw_w > (ctr_w + db_w);
    below     = (raw_w + db_w) < ctr_w;
    num_above = raw_w - ctr_w - db_w;
    den_above = CmpW'(FullScale) - ctr_w - db_w;
    num_below = ctr_w - raw_w;
    if (above) begin
      num_d = num_above[SAMPLE_BITS-1:0];
      den_d = den_above[SAMPLE_BITS-1:0];
    end else if (below) begin
      num_d = num_below[SAMPLE_BITS-1:0];
      den_d = SAMPLE_BITS'(Center);
    end else begin
      num_d = '0;
      den_d = SAMPLE_BITS'(Center);
    end
    neg_d = below ^ cfg.invert_mask[in_chan.channel_select];
  end

  // per-channel table lanes
  always_comb begin
    lane_base = LaneSelW'({ch_q, 4'b0000});
    step_lane = cfg.step_table[lane_base +: LaneW];
    lo_lane   = cfg.low_limit_table[lane_base +: LaneW];
    hi_lane   = cfg.high_limit_table[lane_base +: LaneW];
    lo_q16    = {{(SumW - PosW){lo_lane[LaneW-1]}}, lo_lane, 16'h0000};
    hi_q16    = {{(SumW - PosW){hi_lane[LaneW-1]}}, hi_lane, 16'h0000};
  end

  // selected channel's position
  always_comb begin
    pos_sel = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (int'(ch_q) == i) pos_sel = pos_q[i];
    end
    pos_ext = SumW'(pos_sel);
  end

  // scaled numerator goes straight into the divider's dividend register
  assign product   = ProdW'(num_q) * ProdW'(step_lane);
  assign div_start = (state_q == StPrep);

  jri_div #(
    .NUM_W (ProdW),
    .DEN_W (SAMPLE_BITS)
  ) u_div (
    .clk_i,
    .rst_ni,
    .start_i    (div_start),
    .dividend_i (product),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // signed increment, truncated toward zero
  assign inc = neg_q ? -$signed(SumW'(quotient)) : $signed(SumW'(quotient));

  // clip to the channel limits
  always_comb begin
    if (sum_q < lo_q16) clip_val = lo_q16;
    else if (sum_q > hi_q16) clip_val = hi_q16;
    else clip_val = sum_q;
  end

  assign out_load = (state_q == StClip) && (!out_valid_q || out_chan.ready);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (in_acc && in_chan.op == OpSample && ch_ok) state_d = StPrep;
      StPrep: state_d = StDiv;
      StDiv:  if (div_done) state_d = StSum;
      StSum:  state_d = StClip;
      StClip: if (out_load) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  // request capture and running sum
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ch_q  <= in_chan.channel_select;
      num_q <= num_d;
      den_q <= den_d;
      neg_q <= neg_d;
    end
    if (state_q == StDiv && div_done) sum_q <= pos_ext + inc;
  end

  // channel positions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) pos_q[i] <= '0;
    end else if (in_acc && in_chan.op == OpZero) begin
      for (int i = 0; i < CHANNELS; i++) pos_q[i] <= '0;
    end else if (out_load) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (int'(ch_q) == i) pos_q[i] <= clip_val[PosW-1:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (out_load) out_valid_q <= 1'b1;
    else if (out_chan.ready) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_channel_q <= ch_q;
      position_q    <= clip_val[PosW-1:0];
    end
  end

  assign out_chan.valid       = out_valid_q;
  assign out_chan.out_channel = out_channel_q;
  assign out_chan.position    = position_q;

  // every position is zero
  always_comb begin
    all_zero = 1'b1;
    for (int i = 0; i < CHANNELS; i++) begin
      if (pos_q[i] != '0) all_zero = 1'b0;
    end
  end

  // no new request while a sample is in flight
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_chan.ready)
    else $error("request taken while busy");

  // divider finishes only while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == StDiv))
    else $error("divider done outside divide step");

  // a zero request clears all positions
  a_zero_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_chan.op == OpZero) |=> all_zero)
    else $error("positions not cleared");

  // a result with ordered limits lies within them
  a_clip_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && lo_q16 <= hi_q16) |=>
      (SumW'(position_q) >= $past(lo_q16) && SumW'(position_q) <= $past(hi_q16)))
    else $error("result outside channel limits");

endmodule
